@@ rtl/core/dpm_pkg.sv @@
// Package for the dictionary prefix matcher: sizes, codes and transfer payload types.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package dpm_pkg;

    localparam int NODES        = 2048;
    localparam int NODE_W       = 11;
    localparam int NODE_CNT_W   = 12;
    localparam int MAX_WORD_LEN = 16;
    localparam int LEN_W        = 5;
    localparam int MAX_TEXT     = 262144;
    localparam int POS_W        = 19;
    localparam int ALPHABET     = 26;
    localparam int SYM_W        = 5;
    localparam int GOTO_DEPTH   = NODES * ALPHABET;
    localparam int GADDR_W      = 16;
    localparam int WIN_W        = MAX_WORD_LEN + 1;
    localparam int WALK_MAX     = MAX_WORD_LEN + 1;
    localparam int WALK_W       = 5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_TEXT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_LONG  = 2'd2,
        ST_PHASE = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [SYM_W-1:0] symbol;
        logic             word_end;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] best_prefix;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        logic               we;
        logic [GADDR_W-1:0] waddr;
        logic [NODE_W-1:0]  wdata;
    } goto_wr_t;

endpackage

@@ rtl/core/dpm_goto_ram.sv @@
// Goto table store of the dictionary prefix matcher: one write port, two registered read ports.
// Depends on dpm_pkg.
module dpm_goto_ram (
    input  logic                       clk,
    input  dpm_pkg::goto_wr_t          wr,
    input  logic [dpm_pkg::GADDR_W-1:0] raddr_a,
    output logic [dpm_pkg::NODE_W-1:0]  rdata_a,
    input  logic [dpm_pkg::GADDR_W-1:0] raddr_b,
    output logic [dpm_pkg::NODE_W-1:0]  rdata_b
);

    logic [dpm_pkg::NODE_W-1:0] mem [dpm_pkg::GOTO_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/core/dictionary_prefix_matcher_unit.sv @@
// Top level of the dictionary prefix matcher: sequencer, fail/length/queue stores, result register.
// Depends on dpm_pkg and dpm_goto_ram.
//
// After reset the block clears its goto table (item_ready low) and then takes one item at a time.
// A dictionary symbol passes address, read and update states; a build fills the root goto row,
// then dequeues each trie node (pop, queue read, fail read) and does one goto pair read and one
// write per letter; a text symbol walks the fail chain one node at a time (at most 18 nodes), set
// by the single read port of the fail and length stores. An error item goes straight to output.
// Each result waits in an output register, so the next item is taken once the sequencer is idle.
module dictionary_prefix_matcher_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  dpm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output dpm_pkg::result_t result
);

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_LADDR = 16'h0004,
        S_LRD   = 16'h0008,
        S_LDO   = 16'h0010,
        S_BROOT = 16'h0020,
        S_BPOP  = 16'h0040,
        S_BQW   = 16'h0080,
        S_BFW   = 16'h0100,
        S_BRD   = 16'h0200,
        S_BWR   = 16'h0400,
        S_TADDR = 16'h0800,
        S_TRD   = 16'h1000,
        S_TGET  = 16'h2000,
        S_TWALK = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    localparam logic [dpm_pkg::GADDR_W-1:0] ALPHA_G = dpm_pkg::GADDR_W'(dpm_pkg::ALPHABET);
    localparam logic [dpm_pkg::NODE_W-1:0]  ROOT    = dpm_pkg::NODE_W'(1);

    state_t                              state_reg, state_next;
    logic [dpm_pkg::GADDR_W-1:0]         clr_reg, clr_next;
    dpm_pkg::item_t                      in_reg, in_next;
    dpm_pkg::status_t                    st_reg, st_next;
    dpm_pkg::status_t                    drop_reg, drop_next;
    logic                                phase_reg, phase_next;
    logic [dpm_pkg::NODE_CNT_W-1:0]      free_reg, free_next;
    logic [dpm_pkg::NODE_W-1:0]          cur_reg, cur_next;
    logic [dpm_pkg::LEN_W-1:0]           cnt_reg, cnt_next;
    logic [dpm_pkg::NODE_W-1:0]          ms_reg, ms_next;
    logic [dpm_pkg::WIN_W-1:0]           win_reg, win_next;
    logic [dpm_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [dpm_pkg::POS_W-1:0]           longest_reg, longest_next;
    logic [dpm_pkg::GADDR_W-1:0]         addr_reg, addr_next;
    logic [dpm_pkg::SYM_W-1:0]           idx_reg, idx_next;
    logic [dpm_pkg::NODE_CNT_W-1:0]      head_reg, head_next;
    logic [dpm_pkg::NODE_CNT_W-1:0]      tail_reg, tail_next;
    logic [dpm_pkg::NODE_W-1:0]          u_reg, u_next;
    logic [dpm_pkg::GADDR_W-1:0]         ubase_reg, ubase_next;
    logic [dpm_pkg::GADDR_W-1:0]         fbase_reg, fbase_next;
    logic [dpm_pkg::WALK_W-1:0]          n_reg, n_next;
    dpm_pkg::result_t                    out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    dpm_pkg::goto_wr_t                   gw;
    logic [dpm_pkg::GADDR_W-1:0]         ga_addr, gb_addr;
    logic [dpm_pkg::NODE_W-1:0]          ga_rdata, gb_rdata;

    logic [dpm_pkg::NODE_W-1:0]          fail_mem [dpm_pkg::NODES];
    logic [dpm_pkg::LEN_W-1:0]           wl_mem [dpm_pkg::NODES];
    logic [dpm_pkg::NODE_W-1:0]          q_mem [dpm_pkg::NODES];
    logic [dpm_pkg::NODE_W-1:0]          f_rdata;
    logic [dpm_pkg::LEN_W-1:0]           wl_rdata;
    logic [dpm_pkg::NODE_W-1:0]          q_rdata;

    logic                                f_we, wl_we, q_we;
    logic [dpm_pkg::NODE_W-1:0]          f_waddr, wl_waddr, q_waddr;
    logic [dpm_pkg::NODE_W-1:0]          f_wdata, q_wdata;
    logic [dpm_pkg::LEN_W-1:0]           wl_wdata;
    logic [dpm_pkg::NODE_W-1:0]          fr_addr, q_raddr;

    logic [dpm_pkg::NODE_W-1:0]          v_node;
    logic                                hit;
    logic [dpm_pkg::WIN_W-1:0]           win_sh;
    logic [dpm_pkg::WALK_W-1:0]          n_inc;

    dpm_goto_ram u_goto (
        .clk     (clk),
        .wr      (gw),
        .raddr_a (ga_addr),
        .rdata_a (ga_rdata),
        .raddr_b (gb_addr),
        .rdata_b (gb_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fail_mem[f_waddr] <= f_wdata;
        end
        if (wl_we)
        begin
            wl_mem[wl_waddr] <= wl_wdata;
        end
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        f_rdata  <= fail_mem[fr_addr];
        wl_rdata <= wl_mem[fr_addr];
        q_rdata  <= q_mem[q_raddr];
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign win_sh = win_reg >> wl_rdata;
    assign n_inc  = n_reg + dpm_pkg::WALK_W'(1);
    assign hit    = (wl_rdata != '0)
                 && (wl_rdata <= dpm_pkg::LEN_W'(dpm_pkg::MAX_WORD_LEN))
                 && (dpm_pkg::POS_W'(wl_rdata) <= pos_reg)
                 && win_sh[0];

    always_comb
    begin
        ga_addr = addr_reg;
        gb_addr = fbase_reg + dpm_pkg::GADDR_W'(idx_reg);
        if (state_reg == S_BRD)
        begin
            ga_addr = ubase_reg + dpm_pkg::GADDR_W'(idx_reg);
        end
        q_raddr = head_reg[dpm_pkg::NODE_W-1:0];
        unique case (state_reg)
            S_BQW:   fr_addr = q_rdata;
            S_TGET:  fr_addr = ga_rdata;
            S_TWALK: fr_addr = f_rdata;
            default: fr_addr = u_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        in_next        = in_reg;
        st_next        = st_reg;
        drop_next      = drop_reg;
        phase_next     = phase_reg;
        free_next      = free_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        ms_next        = ms_reg;
        win_next       = win_reg;
        pos_next       = pos_reg;
        longest_next   = longest_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        ubase_next     = ubase_reg;
        fbase_next     = fbase_reg;
        n_next         = n_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        v_node         = ga_rdata;

        gw       = '0;
        f_we     = 1'b0;
        f_waddr  = clr_reg[dpm_pkg::NODE_W-1:0];
        f_wdata  = '0;
        wl_we    = 1'b0;
        wl_waddr = clr_reg[dpm_pkg::NODE_W-1:0];
        wl_wdata = '0;
        q_we     = 1'b0;
        q_waddr  = tail_reg[dpm_pkg::NODE_W-1:0];
        q_wdata  = ga_rdata;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                gw.we    = 1'b1;
                gw.waddr = clr_reg;
                gw.wdata = '0;
                if (clr_reg < dpm_pkg::GADDR_W'(dpm_pkg::NODES))
                begin
                    f_we  = 1'b1;
                    wl_we = 1'b1;
                end
                clr_next = clr_reg + dpm_pkg::GADDR_W'(1);
                if (clr_reg == dpm_pkg::GADDR_W'(dpm_pkg::GOTO_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    in_next    = item;
                    st_next    = dpm_pkg::ST_PHASE;
                    state_next = S_OUT;
                    if (item.operation == dpm_pkg::OP_LOAD && !phase_reg)
                    begin
                        if (item.symbol < dpm_pkg::SYM_W'(dpm_pkg::ALPHABET))
                        begin
                            state_next = S_LADDR;
                        end
                    end
                    else if (item.operation == dpm_pkg::OP_BUILD && !phase_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_BROOT;
                    end
                    else if (item.operation == dpm_pkg::OP_TEXT && phase_reg)
                    begin
                        if (item.symbol < dpm_pkg::SYM_W'(dpm_pkg::ALPHABET)
                            && pos_reg < dpm_pkg::POS_W'(dpm_pkg::MAX_TEXT))
                        begin
                            state_next = S_TADDR;
                        end
                    end
                end
            end
            S_LADDR:
            begin
                addr_next  = dpm_pkg::GADDR_W'(cur_reg) * ALPHA_G
                           + dpm_pkg::GADDR_W'(in_reg.symbol);
                state_next = S_LRD;
            end
            S_LRD:
            begin
                state_next = S_LDO;
            end
            S_LDO:
            begin
                st_next = dpm_pkg::ST_OK;
                if (drop_reg != dpm_pkg::ST_OK)
                begin
                    st_next = drop_reg;
                end
                else if (cnt_reg >= dpm_pkg::LEN_W'(dpm_pkg::MAX_WORD_LEN))
                begin
                    drop_next = dpm_pkg::ST_LONG;
                    st_next   = dpm_pkg::ST_LONG;
                end
                else
                begin
                    if (ga_rdata == '0)
                    begin
                        if (free_reg >= dpm_pkg::NODE_CNT_W'(dpm_pkg::NODES))
                        begin
                            drop_next = dpm_pkg::ST_FULL;
                            st_next   = dpm_pkg::ST_FULL;
                        end
                        else
                        begin
                            v_node    = free_reg[dpm_pkg::NODE_W-1:0];
                            free_next = free_reg + dpm_pkg::NODE_CNT_W'(1);
                            gw.we     = 1'b1;
                            gw.waddr  = addr_reg;
                            gw.wdata  = v_node;
                        end
                    end
                    if (drop_next == dpm_pkg::ST_OK)
                    begin
                        cur_next = v_node;
                        cnt_next = cnt_reg + dpm_pkg::LEN_W'(1);
                    end
                end
                if (in_reg.word_end)
                begin
                    if (drop_next == dpm_pkg::ST_OK)
                    begin
                        wl_we    = 1'b1;
                        wl_waddr = cur_next;
                        wl_wdata = cnt_next;
                    end
                    cur_next  = ROOT;
                    cnt_next  = '0;
                    drop_next = dpm_pkg::ST_OK;
                end
                state_next = S_OUT;
            end
            S_BROOT:
            begin
                gw.we    = 1'b1;
                gw.waddr = dpm_pkg::GADDR_W'(idx_reg);
                gw.wdata = ROOT;
                if (idx_reg == '0)
                begin
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = ROOT;
                end
                head_next = '0;
                tail_next = dpm_pkg::NODE_CNT_W'(1);
                idx_next  = idx_reg + dpm_pkg::SYM_W'(1);
                if (idx_reg == dpm_pkg::SYM_W'(dpm_pkg::ALPHABET - 1))
                begin
                    state_next = S_BPOP;
                end
            end
            S_BPOP:
            begin
                if (head_reg == tail_reg)
                begin
                    cur_next   = ROOT;
                    cnt_next   = '0;
                    drop_next  = dpm_pkg::ST_OK;
                    phase_next = 1'b1;
                    st_next    = dpm_pkg::ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    head_next  = head_reg + dpm_pkg::NODE_CNT_W'(1);
                    state_next = S_BQW;
                end
            end
            S_BQW:
            begin
                u_next     = q_rdata;
                state_next = S_BFW;
            end
            S_BFW:
            begin
                ubase_next = dpm_pkg::GADDR_W'(u_reg) * ALPHA_G;
                fbase_next = dpm_pkg::GADDR_W'(f_rdata) * ALPHA_G;
                idx_next   = '0;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                state_next = S_BWR;
            end
            S_BWR:
            begin
                if (ga_rdata != '0)
                begin
                    f_we      = 1'b1;
                    f_waddr   = ga_rdata;
                    f_wdata   = gb_rdata;
                    q_we      = 1'b1;
                    q_wdata   = ga_rdata;
                    tail_next = tail_reg + dpm_pkg::NODE_CNT_W'(1);
                end
                else
                begin
                    gw.we    = 1'b1;
                    gw.waddr = ubase_reg + dpm_pkg::GADDR_W'(idx_reg);
                    gw.wdata = gb_rdata;
                end
                idx_next   = idx_reg + dpm_pkg::SYM_W'(1);
                state_next = S_BRD;
                if (idx_reg == dpm_pkg::SYM_W'(dpm_pkg::ALPHABET - 1))
                begin
                    state_next = S_BPOP;
                end
            end
            S_TADDR:
            begin
                addr_next  = dpm_pkg::GADDR_W'(ms_reg) * ALPHA_G
                           + dpm_pkg::GADDR_W'(in_reg.symbol);
                pos_next   = pos_reg + dpm_pkg::POS_W'(1);
                state_next = S_TRD;
            end
            S_TRD:
            begin
                state_next = S_TGET;
            end
            S_TGET:
            begin
                ms_next  = ga_rdata;
                win_next = {win_reg[dpm_pkg::WIN_W-2:0], 1'b0};
                n_next   = '0;
                st_next  = dpm_pkg::ST_OK;
                if (ga_rdata == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_TWALK;
                end
            end
            S_TWALK:
            begin
                n_next = n_inc;
                if (hit)
                begin
                    win_next     = win_reg | dpm_pkg::WIN_W'(1);
                    longest_next = pos_reg;
                    state_next   = S_OUT;
                end
                else if (f_rdata == '0 || n_inc > dpm_pkg::WALK_W'(dpm_pkg::WALK_MAX))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.best_prefix = longest_reg;
                    out_next.status      = st_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            drop_reg      <= dpm_pkg::ST_OK;
            phase_reg     <= 1'b0;
            free_reg      <= dpm_pkg::NODE_CNT_W'(2);
            cur_reg       <= ROOT;
            cnt_reg       <= '0;
            ms_reg        <= ROOT;
            win_reg       <= dpm_pkg::WIN_W'(1);
            pos_reg       <= '0;
            longest_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            drop_reg      <= drop_next;
            phase_reg     <= phase_next;
            free_reg      <= free_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            ms_reg        <= ms_next;
            win_reg       <= win_next;
            pos_reg       <= pos_next;
            longest_reg   <= longest_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        st_reg    <= st_next;
        addr_reg  <= addr_next;
        idx_reg   <= idx_next;
        u_reg     <= u_next;
        ubase_reg <= ubase_next;
        fbase_reg <= fbase_next;
        n_reg     <= n_next;
        out_reg   <= out_next;
    end

endmodule
